[hw/rtl/rgbhsv_pkg.sv]
// ----------------------------------------------------------------------------
// rgbhsv_pkg
// Types and constants shared by the RGB to HSV pipeline and its divider.
// ----------------------------------------------------------------------------
package rgbhsv_pkg;

    localparam int CHAN_W    = 8;
    localparam int HUE_W     = 9;

    localparam int HUE_FULL  = 360;
    localparam int HUE_GREEN = HUE_FULL / 3;
    localparam int HUE_BLUE  = HUE_FULL * 2 / 3;
    localparam int CHAN_FULL = 255;

    // Divider geometry: numerator up to 255*360, divisor one channel span,
    // quotient bounded by 360 because |diff| never exceeds the span.
    localparam int DEN_W     = CHAN_W;
    localparam int QUO_W     = 9;
    localparam int NUM_W     = DEN_W + QUO_W;

    // floor(q/6) == (q*171) >> 10 for every q in 0..360
    localparam int RECIP_6     = 171;
    localparam int RECIP_W     = 8;
    localparam int RECIP_SHIFT = 10;
    localparam int PROD_W      = QUO_W + RECIP_W;
    localparam int SEXT_W      = 6;  // largest sixth is 60

    typedef enum logic [1:0] {
        SEC_GREY,
        SEC_RED,
        SEC_GREEN,
        SEC_BLUE
    } sector_t;

    // Control carried alongside the divider stages
    typedef struct packed {
        sector_t             sector;
        logic                neg;
        logic [CHAN_W-1:0]   value;
    } side_t;

endpackage

[hw/rtl/rgbhsv_div.sv]
// ----------------------------------------------------------------------------
// rgbhsv_div
// Pipelined restoring divider, one quotient bit per register stage.
// ----------------------------------------------------------------------------
module rgbhsv_div (
    input  logic                           clk,
    input  logic [rgbhsv_pkg::NUM_W-1:0]   num,
    input  logic [rgbhsv_pkg::DEN_W-1:0]   den,
    output logic [rgbhsv_pkg::QUO_W-1:0]   quo
);
    import rgbhsv_pkg::*;

    logic [DEN_W-1:0] rem_reg [QUO_W];
    logic [QUO_W-1:0] nlo_reg [QUO_W];
    logic [QUO_W-1:0] quo_reg [QUO_W];
    logic [DEN_W-1:0] den_reg [QUO_W];

    genvar k;
    generate
        for (k = 0; k < QUO_W; k++)
        begin : g_step
            logic [DEN_W-1:0] rem_in;
            logic [QUO_W-1:0] nlo_in;
            logic [QUO_W-1:0] quo_in;
            logic [DEN_W-1:0] den_in;
            logic [DEN_W:0]   trial;
            logic [DEN_W:0]   diff;
            logic             take;
            logic [DEN_W-1:0] rem_next;

            if (k == 0)
            begin : g_first
                // top bits are below the divisor since the quotient fits QUO_W
                assign rem_in = num[NUM_W-1:QUO_W];
                assign nlo_in = num[QUO_W-1:0];
                assign quo_in = '0;
                assign den_in = den;
            end
            else
            begin : g_rest
                assign rem_in = rem_reg[k-1];
                assign nlo_in = nlo_reg[k-1];
                assign quo_in = quo_reg[k-1];
                assign den_in = den_reg[k-1];
            end

            assign trial    = {rem_in, nlo_in[QUO_W-1]};
            assign diff     = trial - {1'b0, den_in};
            assign take     = (trial >= {1'b0, den_in});
            assign rem_next = take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];

            always_ff @(posedge clk)
            begin
                rem_reg[k] <= rem_next;
                nlo_reg[k] <= {nlo_in[QUO_W-2:0], 1'b0};
                quo_reg[k] <= {quo_in[QUO_W-2:0], take};
                den_reg[k] <= den_in;
            end
        end
    endgenerate

    assign quo = quo_reg[QUO_W-1];

endmodule

[hw/rtl/rgb_to_hsv.sv]
// ----------------------------------------------------------------------------
// rgb_to_hsv
// Integer RGB to HSV conversion of 8-bit pixels, fully pipelined.
// ----------------------------------------------------------------------------
// The result of a start transfer is strobed on done as it leaves the last stage.
// Throughput: one pixel per clock; busy stays low, a pixel may enter each cycle.
// Depth is set by the two 9-stage dividers (hue and saturation) plus the
// input capture, min/max, scaling, sixth and offset stages around them.
// Reset clears the valid chain only; no result is strobed after reset until
// a pixel has passed through. The receiver cannot stall the pipeline.
// ----------------------------------------------------------------------------
module rgb_to_hsv (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [rgbhsv_pkg::CHAN_W-1:0]     red,
    input  logic [rgbhsv_pkg::CHAN_W-1:0]     green,
    input  logic [rgbhsv_pkg::CHAN_W-1:0]     blue,
    output logic                              done,
    output logic [rgbhsv_pkg::HUE_W-1:0]      hue,
    output logic [rgbhsv_pkg::CHAN_W-1:0]     saturation,
    output logic [rgbhsv_pkg::CHAN_W-1:0]     value
);
    import rgbhsv_pkg::*;

    // ---------------- stage 1: input capture
    logic              v1_reg;
    logic [CHAN_W-1:0] r1_reg, g1_reg, b1_reg;

    // ---------------- stage 2: max / min / sector
    logic              v2_reg;
    logic [CHAN_W-1:0] hi2_reg, span2_reg, adiff2_reg;
    sector_t           sec2_reg;
    logic              neg2_reg;

    logic [CHAN_W-1:0] hi_next, lo_next, span_next, adiff_next;
    sector_t           sec_next;
    logic              neg_next;

    // ---------------- stage 3: scaled numerators
    logic              v3_reg;
    logic [NUM_W-1:0]  hnum3_reg, snum3_reg;
    logic [DEN_W-1:0]  hden3_reg, sden3_reg;
    side_t             side3_reg;

    // ---------------- divider section
    logic [QUO_W-1:0]  hq, sq;
    logic [QUO_W-1:0]  vd_reg;
    side_t             sided_reg [QUO_W];

    // ---------------- stage after divider: sixth
    logic              v4_reg;
    logic [SEXT_W-1:0] h6_reg;
    logic [CHAN_W-1:0] sat4_reg;
    side_t             side4_reg;
    logic [PROD_W-1:0] prod;

    // ---------------- output stage
    logic              done_reg;
    logic [HUE_W-1:0]  hue_reg;
    logic [CHAN_W-1:0] sat_reg, val_reg;
    logic [HUE_W-1:0]  hoff, hue_next;

    // pipeline takes a transfer every cycle
    assign busy = 1'b0;

    // ---------------- valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            vd_reg   <= '0;
            v4_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= start && !busy;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            vd_reg   <= {vd_reg[QUO_W-2:0], v3_reg};
            v4_reg   <= vd_reg[QUO_W-1];
            done_reg <= v4_reg;
        end
    end

    // ---------------- stage 2 logic
    always_comb
    begin
        hi_next = r1_reg;
        lo_next = r1_reg;
        if (g1_reg > hi_next) hi_next = g1_reg;
        if (b1_reg > hi_next) hi_next = b1_reg;
        if (g1_reg < lo_next) lo_next = g1_reg;
        if (b1_reg < lo_next) lo_next = b1_reg;
        span_next = hi_next - lo_next;

        // ties for the largest channel go red, then green, then blue
        if (span_next == '0)
        begin
            sec_next   = SEC_GREY;
            neg_next   = 1'b0;
            adiff_next = '0;
        end
        else if (hi_next == r1_reg)
        begin
            sec_next   = SEC_RED;
            neg_next   = (g1_reg < b1_reg);
            adiff_next = neg_next ? (b1_reg - g1_reg) : (g1_reg - b1_reg);
        end
        else if (hi_next == g1_reg)
        begin
            sec_next   = SEC_GREEN;
            neg_next   = (b1_reg < r1_reg);
            adiff_next = neg_next ? (r1_reg - b1_reg) : (b1_reg - r1_reg);
        end
        else
        begin
            sec_next   = SEC_BLUE;
            neg_next   = (r1_reg < g1_reg);
            adiff_next = neg_next ? (g1_reg - r1_reg) : (r1_reg - g1_reg);
        end
    end

    // ---------------- stage 4 logic: q/6 by reciprocal
    assign prod = PROD_W'(hq) * PROD_W'(RECIP_6);

    // ---------------- output logic: sector offset, sign folded in
    always_comb
    begin
        case (side4_reg.sector)
            SEC_RED:   hoff = side4_reg.neg ? HUE_W'(HUE_FULL) : '0;
            SEC_GREEN: hoff = HUE_W'(HUE_GREEN);
            SEC_BLUE:  hoff = HUE_W'(HUE_BLUE);
            default:   hoff = '0;
        endcase
        if (side4_reg.sector == SEC_GREY)
            hue_next = '0;
        else if (side4_reg.neg)
            hue_next = hoff - HUE_W'(h6_reg);
        else
            hue_next = hoff + HUE_W'(h6_reg);
    end

    // ---------------- payload registers
    always_ff @(posedge clk)
    begin
        r1_reg <= red;
        g1_reg <= green;
        b1_reg <= blue;

        hi2_reg    <= hi_next;
        span2_reg  <= span_next;
        adiff2_reg <= adiff_next;
        sec2_reg   <= sec_next;
        neg2_reg   <= neg_next;

        hnum3_reg        <= NUM_W'(adiff2_reg) * NUM_W'(HUE_FULL);
        snum3_reg        <= NUM_W'(span2_reg) * NUM_W'(CHAN_FULL);
        hden3_reg        <= span2_reg;
        sden3_reg        <= hi2_reg;
        side3_reg.sector <= sec2_reg;
        side3_reg.neg    <= neg2_reg;
        side3_reg.value  <= hi2_reg;

        sided_reg[0] <= side3_reg;
        for (int i = 1; i < QUO_W; i++)
            sided_reg[i] <= sided_reg[i-1];

        h6_reg    <= prod[RECIP_SHIFT+SEXT_W-1:RECIP_SHIFT];
        // grey covers black too: span zero, divisor may be zero
        sat4_reg  <= (sided_reg[QUO_W-1].sector == SEC_GREY) ? '0 : sq[CHAN_W-1:0];
        side4_reg <= sided_reg[QUO_W-1];

        hue_reg <= hue_next;
        sat_reg <= sat4_reg;
        val_reg <= side4_reg.value;
    end

    rgbhsv_div u_hue_div (
        .clk (clk),
        .num (hnum3_reg),
        .den (hden3_reg),
        .quo (hq)
    );

    rgbhsv_div u_sat_div (
        .clk (clk),
        .num (snum3_reg),
        .den (sden3_reg),
        .quo (sq)
    );

    assign done       = done_reg;
    assign hue        = hue_reg;
    assign saturation = sat_reg;
    assign value      = val_reg;

    // ---------------- assertions
    a_black_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        done && (value == '0) |-> (hue == '0) && (saturation == '0))
        else $error("black pixel with non-zero hue or saturation");

    a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (hue <= HUE_W'(HUE_FULL)))
        else $error("hue above full circle");

    a_hue_quo: assert property (@(posedge clk) disable iff (!rst_n)
        vd_reg[QUO_W-1] && (sided_reg[QUO_W-1].sector != SEC_GREY)
        |-> (hq <= QUO_W'(HUE_FULL)))
        else $error("hue quotient out of range");

    a_sat_quo: assert property (@(posedge clk) disable iff (!rst_n)
        vd_reg[QUO_W-1] && (sided_reg[QUO_W-1].sector != SEC_GREY)
        |-> (sq[QUO_W-1] == 1'b0))
        else $error("saturation quotient overflow");

    a_zero_max: assert property (@(posedge clk) disable iff (!rst_n)
        v2_reg && (hi2_reg == '0) |-> (sec2_reg == SEC_GREY))
        else $error("zero maximum not classed as grey");

endmodule

[sim/tb_rgb_to_hsv.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rgb_to_hsv
// Self-checking bench for the RGB to HSV converter. A queue of pixels with
// random idle gaps feeds a clocked driver. A clocked monitor checks every
// strobed result, field by field, against an HSV prediction that is made when
// the pixel transfer happens.
// ----------------------------------------------------------------------------
module tb_rgb_to_hsv;

    import rgbhsv_pkg::*;

    localparam int CLK_HALF     = 6;
    localparam int NUM_RANDOM   = 900;
    localparam int MAX_GAP      = 16;
    localparam int DRAIN_CYCLES = 30;        // longer than the pipeline is deep
    localparam int LIMIT_CYCLES = 200000;

    typedef struct {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        int                gap;              // idle cycles before this pixel
    } pixel_t;

    typedef struct {
        logic [HUE_W-1:0]  hue;
        logic [CHAN_W-1:0] saturation;
        logic [CHAN_W-1:0] value;
    } hsv_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic [CHAN_W-1:0] red = '0;
    logic [CHAN_W-1:0] green = '0;
    logic [CHAN_W-1:0] blue = '0;
    logic              busy;
    logic              done;
    logic [HUE_W-1:0]  hue;
    logic [CHAN_W-1:0] saturation;
    logic [CHAN_W-1:0] value;

    pixel_t pixel_q[$];
    hsv_t   hsv_expected_q[$];
    int     idle_left = 0;
    int     mismatch_count = 0;

    rgb_to_hsv dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .done       (done),
        .hue        (hue),
        .saturation (saturation),
        .value      (value)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    function automatic hsv_t predict_hsv(input logic [CHAN_W-1:0] r8,
                                         input logic [CHAN_W-1:0] g8,
                                         input logic [CHAN_W-1:0] b8);
        int   r;
        int   g;
        int   b;
        int   hi;
        int   lo;
        int   span;
        int   angle;
        int   sat;
        hsv_t res;
        r = r8;
        g = g8;
        b = b8;
        hi = r;
        lo = r;
        if (g > hi) hi = g;
        if (b > hi) hi = b;
        if (g < lo) lo = g;
        if (b < lo) lo = b;
        span = hi - lo;
        // SV int division truncates toward zero, each step on its own
        if (span == 0)
            angle = 0;
        else if (hi == r)
        begin
            angle = (HUE_FULL * (g - b)) / span / 6;
            if (g < b) angle += HUE_FULL;
        end
        else if (hi == g)
            angle = (HUE_FULL * (b - r)) / span / 6 + HUE_FULL / 3;
        else
            angle = (HUE_FULL * (r - g)) / span / 6 + HUE_FULL * 2 / 3;
        sat = (hi != 0) ? (span * CHAN_FULL) / hi : 0;
        res.hue        = HUE_W'(angle);
        res.saturation = CHAN_W'(sat);
        res.value      = CHAN_W'(hi);
        return res;
    endfunction

    task automatic add_pixel(input int r, input int g, input int b, input int gap);
        pixel_t p;
        p.red   = CHAN_W'(r);
        p.green = CHAN_W'(g);
        p.blue  = CHAN_W'(b);
        p.gap   = gap;
        pixel_q.push_back(p);
    endtask

    // Stimulus
    initial
    begin
        int kind;
        int base;
        int r;
        int g;
        int b;
        int gap;

        // directed: extremes, grey/black, each largest channel, ties, hue of 360
        add_pixel(0, 0, 0, 0);
        add_pixel(255, 255, 255, 0);
        add_pixel(128, 128, 128, 0);
        add_pixel(255, 0, 0, 0);
        add_pixel(0, 255, 0, 0);
        add_pixel(0, 0, 255, 0);
        add_pixel(255, 0, 1, 3);
        add_pixel(200, 10, 11, 0);
        add_pixel(255, 255, 0, 0);
        add_pixel(0, 255, 255, 0);
        add_pixel(255, 0, 255, 1);
        add_pixel(1, 0, 0, 0);
        add_pixel(1, 1, 0, 0);
        add_pixel(0, 1, 1, 0);
        add_pixel(1, 0, 1, 0);
        add_pixel(254, 255, 0, 0);
        add_pixel(255, 254, 253, 0);
        add_pixel(10, 200, 5, 5);
        add_pixel(3, 1, 200, 0);
        add_pixel(200, 3, 100, 0);
        add_pixel(0, 100, 255, 0);
        add_pixel(170, 85, 170, 0);

        for (int i = 0; i < NUM_RANDOM; i++)
        begin
            kind = $urandom_range(0, 9);
            r = $urandom_range(0, 255);
            g = $urandom_range(0, 255);
            b = $urandom_range(0, 255);
            case (kind)
                5, 6:
                begin
                    // narrow spans stress the truncation steps
                    base = $urandom_range(0, 252);
                    r = base + $urandom_range(0, 3);
                    g = base + $urandom_range(0, 3);
                    b = base + $urandom_range(0, 3);
                end
                7:
                begin
                    case ($urandom_range(0, 2))
                        0: g = r;
                        1: b = g;
                        default: b = r;
                    endcase
                end
                8:
                begin
                    g = r;
                    b = r;
                end
                9:
                begin
                    case ($urandom_range(0, 2))
                        0: r = $urandom_range(0, 1) ? 255 : 0;
                        1: g = $urandom_range(0, 1) ? 255 : 0;
                        default: b = $urandom_range(0, 1) ? 255 : 0;
                    endcase
                end
                default: ;
            endcase
            // every third block of 64 runs back to back
            gap = ((i / 64) % 3 == 1) ? 0 : $urandom_range(0, MAX_GAP);
            add_pixel(r, g, b, gap);
        end

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pixel_q.size() != 0 || start)
            @(negedge clk);
        while (hsv_expected_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start     <= 1'b0;
            red       <= '0;
            green     <= '0;
            blue      <= '0;
            idle_left <= 0;
        end
        else
        begin
            if (start && !busy)
                hsv_expected_q.push_back(predict_hsv(red, green, blue));

            if (start && busy)
            begin
                // transfer held off, keep the pixel
            end
            else if (idle_left != 0)
            begin
                start     <= 1'b0;
                idle_left <= idle_left - 1;
                red       <= CHAN_W'($urandom);
                green     <= CHAN_W'($urandom);
                blue      <= CHAN_W'($urandom);
            end
            else if (pixel_q.size() != 0 && pixel_q[0].gap != 0)
            begin
                start           <= 1'b0;
                idle_left       <= pixel_q[0].gap - 1;
                pixel_q[0].gap  = 0;
                red             <= CHAN_W'($urandom);
                green           <= CHAN_W'($urandom);
                blue            <= CHAN_W'($urandom);
            end
            else if (pixel_q.size() != 0)
            begin
                start <= 1'b1;
                red   <= pixel_q[0].red;
                green <= pixel_q[0].green;
                blue  <= pixel_q[0].blue;
                void'(pixel_q.pop_front());
            end
            else
                start <= 1'b0;
        end
    end

    // Monitor
    always @(posedge clk or negedge rst_n)
    begin
        hsv_t exp_hsv;
        if (rst_n && done)
        begin
            if (hsv_expected_q.size() == 0)
            begin
                $error("result strobed with no pixel outstanding");
                mismatch_count++;
            end
            else
            begin
                exp_hsv = hsv_expected_q.pop_front();
                if (hue !== exp_hsv.hue)
                begin
                    $error("hue: expected %0d, got %0d", exp_hsv.hue, hue);
                    mismatch_count++;
                end
                if (saturation !== exp_hsv.saturation)
                begin
                    $error("saturation: expected %0d, got %0d",
                           exp_hsv.saturation, saturation);
                    mismatch_count++;
                end
                if (value !== exp_hsv.value)
                begin
                    $error("value: expected %0d, got %0d", exp_hsv.value, value);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        #(2 * CLK_HALF * LIMIT_CYCLES);
        $display("FAILURE");
        $finish;
    end

endmodule
